// ===== src/mfmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mfmc_pkg;

    // Graph sizing
    localparam int MAX_VERTICES = 32;
    localparam int MAX_EDGES    = 256;
    localparam int CAP_BITS     = 24;

    localparam int V_AW      = $clog2(MAX_VERTICES);
    localparam int ARC_SLOTS = 2 * MAX_EDGES;
    localparam int ARC_AW    = $clog2(ARC_SLOTS);
    localparam int ARC_W     = ARC_AW + 1;
    localparam int LEVEL_W   = V_AW + 1;
    localparam int QPTR_W    = V_AW + 1;
    localparam int FLOW_W    = 33;
    localparam int MASK_W    = 32;

    localparam logic [ARC_W-1:0]   NO_ARC     = ARC_W'(ARC_SLOTS);
    localparam logic [LEVEL_W-1:0] LEVEL_NONE = '1;

    // Word layouts
    localparam int IN_BITS  = 2 + 2 * V_AW + 24;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 + FLOW_W + MASK_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 6;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_COMPUTE = 2'd1,
        ACT_CLEAR   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [CFG_AW-1:0] {
        REG_SOURCE = 2'd0,
        REG_SINK   = 2'd1,
        REG_VCOUNT = 2'd2
    } t_reg_idx;

    // Datapath operations, one per cycle
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_ADD_WR0,
        CMD_ADD_LNK0,
        CMD_ADD_WR1,
        CMD_ADD_LNK1,
        CMD_CLEAR,
        CMD_B_INIT,
        CMD_B_POP,
        CMD_B_ARC,
        CMD_B_ARCW,
        CMD_F_INIT,
        CMD_F_TOP,
        CMD_F_SCAN,
        CMD_F_SCANW,
        CMD_F_POP,
        CMD_A_RD,
        CMD_A_WR,
        CMD_A_END,
        CMD_DONE
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       add_ok;
        logic       q_empty;
        logic       arc_null;
        logic       arc_take;
        logic       at_sink;
        logic       depth_zero;
        logic       aug_last;
        logic       cut_done;
        logic       out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== src/mfmc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mfmc_ctrl
    import mfmc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output t_cmd          o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE,
        S_ADD_WR0, S_ADD_LNK0, S_ADD_WR1, S_ADD_LNK1,
        S_CLEAR,
        S_B_INIT, S_B_POP, S_B_ARC, S_B_ARCW, S_B_END,
        S_F_INIT, S_F_TOP, S_F_SCAN, S_F_SCANW, S_F_POP,
        S_A_RD, S_A_WR, S_A_END,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_DECODE;
            S_DECODE: begin
                case (i_stat.action)
                    ACT_ADD:     n_state = i_stat.add_ok ? S_ADD_WR0 : S_DONE;
                    ACT_COMPUTE: n_state = S_B_INIT;
                    ACT_CLEAR:   n_state = S_CLEAR;
                    default:     n_state = S_DONE;
                endcase
            end
            S_ADD_WR0:  n_state = S_ADD_LNK0;
            S_ADD_LNK0: n_state = S_ADD_WR1;
            S_ADD_WR1:  n_state = S_ADD_LNK1;
            S_ADD_LNK1: n_state = S_DONE;
            S_CLEAR:    n_state = S_DONE;
            S_B_INIT:   n_state = S_B_POP;
            S_B_POP:    n_state = i_stat.q_empty ? S_B_END : S_B_ARC;
            S_B_ARC:    n_state = i_stat.arc_null ? S_B_POP : S_B_ARCW;
            S_B_ARCW:   n_state = S_B_ARC;
            S_B_END:    n_state = i_stat.cut_done ? S_DONE : S_F_INIT;
            S_F_INIT:   n_state = S_F_TOP;
            S_F_TOP:    n_state = i_stat.at_sink ? S_A_RD : S_F_SCAN;
            S_F_SCAN:   n_state = i_stat.arc_null ? S_F_POP : S_F_SCANW;
            S_F_SCANW:  n_state = i_stat.arc_take ? S_F_TOP : S_F_SCAN;
            S_F_POP:    n_state = i_stat.depth_zero ? S_B_INIT : S_F_TOP;
            S_A_RD:     n_state = S_A_WR;
            S_A_WR:     n_state = i_stat.aug_last ? S_A_END : S_A_RD;
            S_A_END:    n_state = S_F_TOP;
            S_DONE:     if (i_stat.out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command decode
    always_comb begin
        unique case (r_state)
            S_IDLE:     o_cmd = i_in_valid ? CMD_LOAD : CMD_NONE;
            S_ADD_WR0:  o_cmd = CMD_ADD_WR0;
            S_ADD_LNK0: o_cmd = CMD_ADD_LNK0;
            S_ADD_WR1:  o_cmd = CMD_ADD_WR1;
            S_ADD_LNK1: o_cmd = CMD_ADD_LNK1;
            S_CLEAR:    o_cmd = CMD_CLEAR;
            S_B_INIT:   o_cmd = CMD_B_INIT;
            S_B_POP:    o_cmd = CMD_B_POP;
            S_B_ARC:    o_cmd = CMD_B_ARC;
            S_B_ARCW:   o_cmd = CMD_B_ARCW;
            S_F_INIT:   o_cmd = CMD_F_INIT;
            S_F_TOP:    o_cmd = CMD_F_TOP;
            S_F_SCAN:   o_cmd = CMD_F_SCAN;
            S_F_SCANW:  o_cmd = CMD_F_SCANW;
            S_F_POP:    o_cmd = CMD_F_POP;
            S_A_RD:     o_cmd = CMD_A_RD;
            S_A_WR:     o_cmd = CMD_A_WR;
            S_A_END:    o_cmd = CMD_A_END;
            S_DONE:     o_cmd = i_stat.out_free ? CMD_DONE : CMD_NONE;
            default:    o_cmd = CMD_NONE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

// ===== src/mfmc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mfmc_dp
    import mfmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [IN_W-1:0]   i_in_data,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [OUT_W-1:0]       o_out_data,
    output t_dp_stat               o_stat
);

    // Configuration
    logic [V_AW-1:0] r_src, r_snk;
    logic [5:0]      r_vcount;

    // Current item
    logic [1:0]          r_action;
    logic [V_AW-1:0]     r_from, r_to;
    logic [CAP_BITS-1:0] r_cap;
    t_status             r_status;
    logic [FLOW_W-1:0]   r_flow;

    // Arc store
    logic [CAP_BITS-1:0] res_mem  [ARC_SLOTS];
    logic [V_AW-1:0]     head_mem [ARC_SLOTS];
    logic [ARC_W-1:0]    next_mem [ARC_SLOTS];
    logic [CAP_BITS-1:0] r_rd_res;
    logic [V_AW-1:0]     r_rd_head;
    logic [ARC_W-1:0]    r_rd_next;

    // Per-vertex state
    logic [ARC_W-1:0]   r_first  [MAX_VERTICES];
    logic [ARC_W-1:0]   r_last   [MAX_VERTICES];
    logic [ARC_W-1:0]   r_cursor [MAX_VERTICES];
    logic [LEVEL_W-1:0] r_level  [MAX_VERTICES];
    logic [ARC_W-1:0]   r_count;

    // Search queue and path stacks
    logic [V_AW-1:0]     r_queue  [MAX_VERTICES];
    logic [QPTR_W-1:0]   r_qh, r_qt;
    logic [ARC_AW-1:0]   r_pstack [MAX_VERTICES];
    logic [ARC_W-1:0]    r_nstack [MAX_VERTICES];
    logic [V_AW-1:0]     r_vstack [MAX_VERTICES];
    logic [CAP_BITS-1:0] r_rstack [MAX_VERTICES];
    logic [CAP_BITS-1:0] r_mstack [MAX_VERTICES];
    logic [V_AW-1:0]     r_depth, r_i;
    logic [V_AW-1:0]     r_u;
    logic [ARC_W-1:0]    r_a;
    logic [CAP_BITS-1:0] r_b;

    // Output word
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    // Input fields
    logic [1:0]          w_in_action;
    logic [V_AW-1:0]     w_in_from, w_in_to;
    logic [CAP_BITS-1:0] w_in_cap;
    assign w_in_action = i_in_data[1:0];
    assign w_in_from   = i_in_data[2 +: V_AW];
    assign w_in_to     = i_in_data[2 + V_AW +: V_AW];
    assign w_in_cap    = i_in_data[2 + 2 * V_AW +: CAP_BITS];

    // Add checks
    logic w_bad, w_full;
    assign w_bad  = ({1'b0, w_in_from} >= r_vcount) || ({1'b0, w_in_to} >= r_vcount);
    assign w_full = r_count > ARC_W'(ARC_SLOTS - 2);

    // Search helpers
    logic [V_AW-1:0]     w_link_tail;
    logic [ARC_W-1:0]    w_link_last;
    logic [ARC_AW-1:0]   w_p;
    logic [V_AW-1:0]     w_dm1;
    logic [CAP_BITS-1:0] w_min;
    logic                w_take;
    logic [MASK_W-1:0]   w_mask;

    assign w_link_tail = (i_cmd == CMD_ADD_LNK0) ? r_from : r_to;
    assign w_link_last = r_last[w_link_tail];
    assign w_p         = r_pstack[r_i];
    assign w_dm1       = r_depth - V_AW'(1);
    assign w_min       = (r_depth == '0 || r_rd_res < r_mstack[w_dm1]) ?
                         r_rd_res : r_mstack[w_dm1];
    assign w_take      = (r_rd_res != '0) &&
                         (r_level[r_rd_head] == r_level[r_u] + LEVEL_W'(1));

    always_comb begin
        for (int v = 0; v < MASK_W; v++) begin
            w_mask[v] = (r_level[v] != LEVEL_NONE);
        end
    end

    // Arc store ports
    logic                w_res_we, w_head_we, w_nx_we;
    logic [ARC_AW-1:0]   w_wr_addr, w_nx_addr, w_rd_addr;
    logic [CAP_BITS-1:0] w_wr_res;
    logic [V_AW-1:0]     w_wr_head;
    logic [ARC_W-1:0]    w_nx_data;

    always_comb begin
        w_res_we  = 1'b0;
        w_head_we = 1'b0;
        w_nx_we   = 1'b0;
        w_wr_addr = r_count[ARC_AW-1:0];
        w_nx_addr = r_count[ARC_AW-1:0];
        w_rd_addr = r_a[ARC_AW-1:0];
        w_wr_res  = r_cap;
        w_wr_head = r_to;
        w_nx_data = NO_ARC;
        case (i_cmd)
            CMD_ADD_WR0: begin
                w_res_we  = 1'b1;
                w_head_we = 1'b1;
                w_nx_we   = 1'b1;
            end
            CMD_ADD_WR1: begin
                w_res_we  = 1'b1;
                w_head_we = 1'b1;
                w_nx_we   = 1'b1;
                w_wr_res  = '0;
                w_wr_head = r_from;
            end
            CMD_ADD_LNK0, CMD_ADD_LNK1: begin
                w_nx_we   = (w_link_last != NO_ARC);
                w_nx_addr = w_link_last[ARC_AW-1:0];
                w_nx_data = r_count;
            end
            CMD_A_RD: begin
                w_res_we  = 1'b1;
                w_wr_addr = w_p;
                w_wr_res  = r_rstack[r_i] - r_b;
                w_rd_addr = w_p ^ ARC_AW'(1);
            end
            CMD_A_WR: begin
                w_res_we  = 1'b1;
                w_wr_addr = w_p ^ ARC_AW'(1);
                w_wr_res  = r_rd_res + r_b;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_res_we) res_mem[w_wr_addr] <= w_wr_res;
        if (w_head_we) head_mem[w_wr_addr] <= w_wr_head;
        if (w_nx_we) next_mem[w_nx_addr] <= w_nx_data;
        r_rd_res  <= res_mem[w_rd_addr];
        r_rd_head <= head_mem[w_rd_addr];
        r_rd_next <= next_mem[w_rd_addr];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src    <= '0;
            r_snk    <= V_AW'(31);
            r_vcount <= 6'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SOURCE: r_src    <= i_cfg_data[V_AW-1:0];
                REG_SINK:   r_snk    <= i_cfg_data[V_AW-1:0];
                REG_VCOUNT: r_vcount <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Main datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int v = 0; v < MAX_VERTICES; v++) begin
                r_first[v]  <= NO_ARC;
                r_last[v]   <= NO_ARC;
                r_level[v]  <= LEVEL_NONE;
                r_cursor[v] <= '0;
            end
        end else begin
            if (i_out_ready && i_cmd != CMD_DONE) r_out_valid <= 1'b0;
            case (i_cmd)
                CMD_LOAD: begin
                    r_action <= w_in_action;
                    r_from   <= w_in_from;
                    r_to     <= w_in_to;
                    r_cap    <= w_in_cap;
                    r_flow   <= '0;
                    if (w_in_action == ACT_ADD && w_bad) r_status <= ST_RANGE;
                    else if (w_in_action == ACT_ADD && w_full) r_status <= ST_FULL;
                    else r_status <= ST_OK;
                end
                CMD_ADD_LNK0, CMD_ADD_LNK1: begin
                    if (w_link_last == NO_ARC) r_first[w_link_tail] <= r_count;
                    r_last[w_link_tail] <= r_count;
                    r_count <= r_count + ARC_W'(1);
                end
                CMD_CLEAR: begin
                    r_count <= '0;
                    for (int v = 0; v < MAX_VERTICES; v++) begin
                        r_first[v]  <= NO_ARC;
                        r_last[v]   <= NO_ARC;
                        r_level[v]  <= LEVEL_NONE;
                        r_cursor[v] <= '0;
                    end
                end
                // level search
                CMD_B_INIT: begin
                    for (int v = 0; v < MAX_VERTICES; v++) begin
                        r_level[v] <= (V_AW'(v) == r_src) ? '0 : LEVEL_NONE;
                    end
                    r_queue[0]     <= r_src;
                    r_qh           <= '0;
                    r_qt           <= QPTR_W'(1);
                end
                CMD_B_POP: begin
                    r_u  <= r_queue[r_qh[V_AW-1:0]];
                    r_a  <= r_first[r_queue[r_qh[V_AW-1:0]]];
                    r_qh <= r_qh + QPTR_W'(1);
                end
                CMD_B_ARCW: begin
                    if (r_rd_res != '0 && r_level[r_rd_head] == LEVEL_NONE) begin
                        r_level[r_rd_head]      <= r_level[r_u] + LEVEL_W'(1);
                        r_queue[r_qt[V_AW-1:0]] <= r_rd_head;
                        r_qt                    <= r_qt + QPTR_W'(1);
                    end
                    r_a <= r_rd_next;
                end
                // blocking flow
                CMD_F_INIT: begin
                    for (int v = 0; v < MAX_VERTICES; v++) r_cursor[v] <= r_first[v];
                    r_depth     <= '0;
                    r_vstack[0] <= r_src;
                end
                CMD_F_TOP: begin
                    r_u <= r_vstack[r_depth];
                    r_a <= r_cursor[r_vstack[r_depth]];
                    r_b <= r_mstack[w_dm1];
                    r_i <= '0;
                end
                CMD_F_SCANW: begin
                    if (w_take) begin
                        r_cursor[r_u]                 <= r_a;
                        r_pstack[r_depth]             <= r_a[ARC_AW-1:0];
                        r_nstack[r_depth]             <= r_rd_next;
                        r_rstack[r_depth]             <= r_rd_res;
                        r_mstack[r_depth]             <= w_min;
                        r_vstack[r_depth + V_AW'(1)]  <= r_rd_head;
                        r_depth                       <= r_depth + V_AW'(1);
                    end else begin
                        r_a <= r_rd_next;
                    end
                end
                CMD_F_POP: begin
                    r_cursor[r_u] <= NO_ARC;
                    if (r_depth != '0) begin
                        r_cursor[r_vstack[w_dm1]] <= r_nstack[w_dm1];
                        r_depth                   <= w_dm1;
                    end
                end
                // augmentation
                CMD_A_WR: r_i <= r_i + V_AW'(1);
                CMD_A_END: begin
                    r_flow  <= r_flow + FLOW_W'(r_b);
                    r_depth <= '0;
                end
                CMD_DONE: begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= OUT_W'({(r_action == ACT_COMPUTE) ? w_mask : '0,
                                           r_flow, r_status});
                end
                default: ;
            endcase
        end
    end

    // Status to controller
    always_comb begin
        o_stat.action     = r_action;
        o_stat.add_ok     = (r_status == ST_OK);
        o_stat.q_empty    = (r_qh == r_qt);
        o_stat.arc_null   = r_a[ARC_W-1];
        o_stat.arc_take   = w_take;
        o_stat.at_sink    = (r_depth != '0) && (r_vstack[r_depth] == r_snk);
        o_stat.depth_zero = (r_depth == '0);
        o_stat.aug_last   = (r_i == w_dm1);
        o_stat.cut_done   = (r_src == r_snk) || (r_level[r_snk] == LEVEL_NONE);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// ===== src/max_flow_min_cut_unit.sv =====
// Maximum flow / minimum cut engine (level search plus blocking flow).
// Input words on the s_ side carry one command each: add an edge, compute
// flow and cut, or clear the graph. Every command returns exactly one word
// on the m_ side with status, flow added and the source-side vertex mask.
// Source, sink and vertex count must be written through the cfg port while
// idle; the block itself does not enforce it. An add writes and links the
// forward arc, then the reverse arc; a clear resets the arc count and the
// vertex lists. A compute repeats the level search and the path search with
// augmentation, through an arc store with one read and one write per cycle.
// One command is worked at a time; the next word is taken once the result
// sits in the output register.
// Reset empties the graph and restores source 0, sink 31, vertex count 32;
// no clearing pass is needed. When the receiver stalls, the result waits in
// the output register and the engine holds in its final step until it is
// taken.
`timescale 1ns / 1ps
`default_nettype none
module max_flow_min_cut_unit
    import mfmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // action[1:0], from_vertex[6:2], to_vertex[11:7], capacity[35:12]
    input  wire logic [IN_W-1:0]   i_s_tdata,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // status[1:0], flow_added[34:2], source_side_mask[66:35]
    output logic [OUT_W-1:0]       o_m_tdata,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_DW-1:0] i_cfg_data
);

    t_cmd     w_cmd;
    t_dp_stat w_stat;

    mfmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    mfmc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata),
        .o_stat      (w_stat)
    );

endmodule
`default_nettype wire
